/* rtl/core/dmtt_pkg.sv */
// ----------------------------------------------------------------------------
// dmtt_pkg: shared types and constants of the transposition table
// Slot layout, request and result records, operation and flag codes.
// ----------------------------------------------------------------------------
package dmtt_pkg;

  localparam int INDEX_BITS        = 12;
  localparam int MOVE_BITS         = 8;
  localparam int KEY_BITS          = 64;
  localparam int SCORE_BITS        = 16;
  localparam int IN_DEPTH_BITS     = 8;
  localparam int SLOT_DEPTH_BITS   = 7;
  localparam int FLAG_BITS         = 2;
  localparam int IN_MOVE_BITS      = 8;
  localparam int GEN_BITS          = 8;

  typedef logic [1:0]                 kind_t;
  typedef logic [KEY_BITS-1:0]        key_t;
  typedef logic [SCORE_BITS-1:0]      score_t;
  typedef logic [IN_DEPTH_BITS-1:0]   in_depth_t;
  typedef logic [SLOT_DEPTH_BITS-1:0] slot_depth_t;
  typedef logic [FLAG_BITS-1:0]       flag_t;
  typedef logic [MOVE_BITS-1:0]       move_t;
  typedef logic [IN_MOVE_BITS-1:0]    in_move_t;
  typedef logic [GEN_BITS-1:0]        gen_t;
  typedef logic [INDEX_BITS-1:0]      slot_idx_t;

  localparam kind_t KIND_STORE = 2'd0;
  localparam kind_t KIND_PROBE = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  localparam flag_t       FLAG_NONE = 2'd0;
  localparam slot_depth_t DEPTH_CAP = 7'd127;
  localparam gen_t        GEN_RESET = 8'd1;
  localparam key_t        KEY_EMPTY = '0;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // One table slot as it sits in memory.
  typedef struct packed {
    key_t        key;
    score_t      score;
    slot_depth_t depth;
    flag_t       flag;
    move_t       move;
    gen_t        gen;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Captured input transaction.
  typedef struct packed {
    kind_t     kind;
    key_t      key;
    in_depth_t depth;
    score_t    score;
    flag_t     flag;
    in_move_t  move;
  } req_t;

  // Probe answer as presented on the result channel.
  typedef struct packed {
    logic       hit;
    score_t     score;
    slot_depth_t depth;
    flag_t      flag;
    in_move_t   move;
    gen_t       gen;
  } result_t;

endpackage

/* rtl/core/dmtt_if.sv */
// ----------------------------------------------------------------------------
// dmtt_if: channel interfaces of the transposition table
// Valid/ready channels for operation requests and probe results.
// ----------------------------------------------------------------------------
interface dmtt_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [63:0]           position_key;
  logic [7:0]            search_depth;
  logic signed [15:0]    eval_score;
  logic [1:0]            bound_flag;
  logic [7:0]            best_move;

  modport source (
    output valid, kind, position_key, search_depth, eval_score, bound_flag, best_move,
    input  ready
  );
  modport sink (
    input  valid, kind, position_key, search_depth, eval_score, bound_flag, best_move,
    output ready
  );
endinterface

interface dmtt_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [15:0] entry_score;
  logic [6:0]         entry_depth;
  logic [1:0]         entry_flag;
  logic [7:0]         entry_move;
  logic [7:0]         entry_generation;

  modport source (
    output valid, hit, entry_score, entry_depth, entry_flag, entry_move, entry_generation,
    input  ready
  );
  modport sink (
    input  valid, hit, entry_score, entry_depth, entry_flag, entry_move, entry_generation,
    output ready
  );
endinterface

/* rtl/core/dmtt_ram.sv */
// ----------------------------------------------------------------------------
// dmtt_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module dmtt_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem_r [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/dmtt_slot_eval.sv */
// ----------------------------------------------------------------------------
// dmtt_slot_eval: slot update and probe match logic
// Decides replacement for a store, builds the new slot and the probe answer.
// ----------------------------------------------------------------------------
module dmtt_slot_eval (
  input  dmtt_pkg::req_t    req,
  input  dmtt_pkg::entry_t  rd_entry,
  input  dmtt_pkg::gen_t    gen,
  output logic              replace,
  output dmtt_pkg::entry_t  wr_entry,
  output dmtt_pkg::result_t result
);

  logic hit;

  // Depth-preferred replacement: empty slot, same key, or at least as deep.
  assign replace = (rd_entry.key == dmtt_pkg::KEY_EMPTY) || (rd_entry.key == req.key) ||
                   (req.depth >= dmtt_pkg::in_depth_t'(rd_entry.depth));

  always_comb begin
    wr_entry.key   = req.key;
    wr_entry.score = req.score;
    wr_entry.depth = req.depth[dmtt_pkg::IN_DEPTH_BITS-1] ? dmtt_pkg::DEPTH_CAP
                     : req.depth[dmtt_pkg::SLOT_DEPTH_BITS-1:0];
    wr_entry.flag  = req.flag;
    wr_entry.move  = dmtt_pkg::move_t'(req.move);
    wr_entry.gen   = gen;
  end

  assign hit = (rd_entry.key == req.key) && (rd_entry.flag != dmtt_pkg::FLAG_NONE);

  // Zero every field on a miss.
  always_comb begin
    result = '0;
    if (hit) begin
      result.hit   = 1'b1;
      result.score = rd_entry.score;
      result.depth = rd_entry.depth;
      result.flag  = rd_entry.flag;
      result.move  = dmtt_pkg::in_move_t'(rd_entry.move);
      result.gen   = rd_entry.gen;
    end
  end

endmodule

/* rtl/core/direct_mapped_transposition_table_core.sv */
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table_core: direct-mapped transposition table
// Store and probe each do one RAM read, then a write or a result; a probe waits
// in lookup until the output register is free or draining, then loads its result.
// A clear advances the generation and sweeps the table: one slot/cycle.
// After reset the same sweep zeroes every slot before the
// first transaction is accepted; the generation counter resets to one.
// ----------------------------------------------------------------------------
module direct_mapped_transposition_table_core (
  input  logic        clk,
  input  logic        rst_n,
  dmtt_in_if.sink     in_ch,
  dmtt_out_if.source  out_ch
);

  // Sequencer state and captured request
  dmtt_pkg::state_t    state_r, state_nxt;
  dmtt_pkg::slot_idx_t sweep_r, sweep_nxt;
  dmtt_pkg::gen_t      gen_r, gen_nxt;
  dmtt_pkg::req_t      req_r;

  // Result register (skid between the table and the result channel)
  logic                out_valid_r, out_valid_nxt;
  dmtt_pkg::result_t   out_data_r;

  // RAM ports
  logic                          ram_we;
  dmtt_pkg::slot_idx_t           ram_waddr;
  logic [dmtt_pkg::ENTRY_BITS-1:0] ram_wdata;
  logic                          ram_re;
  logic [dmtt_pkg::ENTRY_BITS-1:0] ram_rdata;

  // Slot evaluation
  logic                accept;
  logic                replace;
  logic                out_load;
  dmtt_pkg::entry_t    rd_entry;
  dmtt_pkg::entry_t    wr_entry;
  dmtt_pkg::result_t   probe_result;

  // Accept only when idle; a waiting result blocks the input side only once
  // the next probe reaches lookup.
  assign in_ch.ready = (state_r == dmtt_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Launch the slot read in the accepting cycle for store and probe.
  assign ram_re = accept &&
                  ((in_ch.kind == dmtt_pkg::KIND_STORE) || (in_ch.kind == dmtt_pkg::KIND_PROBE));

  // Hold the request for the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.kind  <= in_ch.kind;
      req_r.key   <= in_ch.position_key;
      req_r.depth <= in_ch.search_depth;
      req_r.score <= in_ch.eval_score;
      req_r.flag  <= in_ch.bound_flag;
      req_r.move  <= in_ch.best_move;
    end
  end

  assign rd_entry = dmtt_pkg::entry_t'(ram_rdata);

  dmtt_slot_eval u_slot_eval (
    .req      (req_r),
    .rd_entry (rd_entry),
    .gen      (gen_r),
    .replace  (replace),
    .wr_entry (wr_entry),
    .result   (probe_result)
  );

  // Load the probe answer once the output register is free or draining.
  assign out_load = (state_r == dmtt_pkg::ST_LOOKUP) && (req_r.kind == dmtt_pkg::KIND_PROBE) &&
                    (!out_valid_r || out_ch.ready);

  // Next state, sweep address, generation and RAM write port.
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    gen_nxt   = gen_r;
    ram_we    = 1'b0;
    ram_waddr = req_r.key[dmtt_pkg::INDEX_BITS-1:0];
    ram_wdata = wr_entry;
    case (state_r)
      dmtt_pkg::ST_SWEEP: begin
        // Zero one slot per cycle; an all-zero slot reads as empty.
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          state_nxt = dmtt_pkg::ST_IDLE;
        end
      end
      dmtt_pkg::ST_IDLE: begin
        if (accept) begin
          if (ram_re) begin
            state_nxt = dmtt_pkg::ST_LOOKUP;
          end else if (in_ch.kind == dmtt_pkg::KIND_CLEAR) begin
            // Advance the generation now; the sweep follows.
            gen_nxt   = gen_r + 1'b1;
            sweep_nxt = '0;
            state_nxt = dmtt_pkg::ST_SWEEP;
          end
        end
      end
      dmtt_pkg::ST_LOOKUP: begin
        if (req_r.kind == dmtt_pkg::KIND_STORE) begin
          ram_we    = replace;
          state_nxt = dmtt_pkg::ST_IDLE;
        end else if (out_load) begin
          state_nxt = dmtt_pkg::ST_IDLE;
        end
        // Otherwise hold: read data stays in the RAM output register.
      end
      default: begin
        state_nxt = dmtt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmtt_pkg::ST_SWEEP;
      sweep_r <= '0;
      gen_r   <= dmtt_pkg::GEN_RESET;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      gen_r   <= gen_nxt;
    end
  end

  dmtt_ram #(
    .ADDR_BITS (dmtt_pkg::INDEX_BITS),
    .DATA_BITS (dmtt_pkg::ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_ch.position_key[dmtt_pkg::INDEX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Result register: set on load, drop on a taken transaction.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= probe_result;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.hit              = out_data_r.hit;
  assign out_ch.entry_score      = out_data_r.score;
  assign out_ch.entry_depth      = out_data_r.depth;
  assign out_ch.entry_flag       = out_data_r.flag;
  assign out_ch.entry_move       = out_data_r.move;
  assign out_ch.entry_generation = out_data_r.gen;

`ifndef SYNTHESIS
  a_lookup_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> state_r == dmtt_pkg::ST_LOOKUP)
    else $error("store or probe did not enter lookup");

  a_clear_bumps_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.kind == dmtt_pkg::KIND_CLEAR)
      |=> (gen_r == dmtt_pkg::gen_t'($past(gen_r) + 8'd1)) && state_r == dmtt_pkg::ST_SWEEP)
    else $error("clear did not advance generation and start sweep");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dmtt_pkg::ST_IDLE |-> !ram_we)
    else $error("table written while idle");

  a_probe_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmtt_pkg::ST_LOOKUP && req_r.kind == dmtt_pkg::KIND_PROBE &&
     out_valid_r && !out_ch.ready) |=> state_r == dmtt_pkg::ST_LOOKUP)
    else $error("probe result dropped while output stalled");
`endif

endmodule
